>>> hw/rtl/snlm_pkg.sv
// Shared types, constants and helpers for the serpentine LED frame buffer.
package snlm_pkg;

  localparam int SIDE_DEFAULT      = 5;
  localparam int LED_COUNT_DEFAULT = 25;
  localparam int COORD_W           = 11;
  localparam int LEVEL_W           = 8;
  localparam int POS_W             = 5;
  localparam int CMD_W             = 2;

  localparam logic [LEVEL_W-1:0] MAX_INTENSITY_RESET = 8'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] b;
  } color_t;

  // Per-step control from the sequencer to the cell ring.
  typedef struct packed {
    logic shift;
    logic write;
    logic emit;
    logic last;
  } ctl_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] level,
                                                      input logic [LEVEL_W-1:0] limit);
    clamp_level = (level > limit) ? limit : level;
  endfunction

endpackage

>>> hw/rtl/snlm_cell.sv
// One storage cell of the frame ring: holds one LED color, loads from its neighbor.
module snlm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  snlm_pkg::color_t d,
  output snlm_pkg::color_t q
);
  import snlm_pkg::*;

  color_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= d;
    end
  end

  assign q = value;

endmodule

>>> hw/rtl/snlm_ctrl.sv
// Sequencer: walks the chain positions once per command and decides each cell's update.
module snlm_ctrl #(
  parameter int SIDE      = snlm_pkg::SIDE_DEFAULT,
  parameter int LED_COUNT = snlm_pkg::LED_COUNT_DEFAULT,
  localparam int XY_W     = $clog2(SIDE),
  localparam int CNT_W    = $clog2(LED_COUNT)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  snlm_pkg::cmd_t     cmd,
  input  logic [XY_W-1:0]    x1,
  input  logic [XY_W-1:0]    y1,
  input  logic [XY_W-1:0]    x2,
  input  logic [XY_W-1:0]    y2,
  input  logic               out_free,
  output logic               busy,
  output logic [CNT_W-1:0]   pos,
  output snlm_pkg::ctl_t     ctl
);
  import snlm_pkg::*;

  localparam int ROW_W = $clog2((LED_COUNT - 1) / SIDE + 2);
  localparam int CW    = ROW_W + XY_W;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(LED_COUNT - 1);
  localparam logic [XY_W-1:0]  LAST_COL = XY_W'(SIDE - 1);

  state_t          state;
  state_t          state_next;
  cmd_t            cmd_q;
  logic [XY_W-1:0] x_lo;
  logic [XY_W-1:0] x_hi;
  logic [XY_W-1:0] y_lo;
  logic [XY_W-1:0] y_hi;
  logic [XY_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [XY_W-1:0] x_cur;
  logic            in_rect;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd;
      pos   <= '0;
      col   <= '0;
      row   <= '0;
      // Order the corners; a single pixel is a one-cell rectangle.
      if (cmd == CMD_SET) begin
        x_lo <= x1;
        x_hi <= x1;
        y_lo <= y1;
        y_hi <= y1;
      end else begin
        x_lo <= (x1 > x2) ? x2 : x1;
        x_hi <= (x1 > x2) ? x1 : x2;
        y_lo <= (y1 > y2) ? y2 : y1;
        y_hi <= (y1 > y2) ? y1 : y2;
      end
    end else if (ctl.shift) begin
      pos <= pos + CNT_W'(1);
      if (col == LAST_COL) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + XY_W'(1);
      end
    end
  end

  // Even rows run right to left along the chain.
  assign x_cur   = row[0] ? col : (LAST_COL - col);
  assign in_rect = (CW'(x_cur) >= CW'(x_lo)) && (CW'(x_cur) <= CW'(x_hi)) &&
                   (CW'(row) >= CW'(y_lo)) && (CW'(row) <= CW'(y_hi));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ctl.shift && (pos == LAST_POS)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state == ST_RUN);
    ctl.shift = busy && ((cmd_q != CMD_UPDATE) || out_free);
    ctl.emit  = ctl.shift && (cmd_q == CMD_UPDATE);
    ctl.last  = (pos == LAST_POS);
    case (cmd_q)
      CMD_FILL:  ctl.write = ctl.shift && in_rect;
      CMD_SET:   ctl.write = ctl.shift && in_rect;
      CMD_CLEAR: ctl.write = ctl.shift;
      default:   ctl.write = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/snake_led_matrix_frame_buffer.sv
// Top level of the serpentine LED matrix frame buffer.
// The frame lives in a ring of LED_COUNT cells, one per LED in chain order, that rotates by
// one position per cycle while a command runs, unless an update waits on a stalled output.
// Every command makes exactly one full turn of the ring, so each accepted word keeps the
// input stalled until the turn ends. Fill and set pixel rewrite the cell passing the head
// when it lies in the rectangle, clear rewrites every cell; update sends each LED as one
// output word (green, red, blue, with last_led on the final one) through an output register.
// Intensities are clamped to max_intensity when a command is accepted. The frame is zero
// and max_intensity is 4 after reset.
module snake_led_matrix_frame_buffer #(
  parameter int SIDE      = snlm_pkg::SIDE_DEFAULT,
  parameter int LED_COUNT = snlm_pkg::LED_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [snlm_pkg::LEVEL_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [snlm_pkg::CMD_W-1:0]          cmd,
  input  logic signed [snlm_pkg::COORD_W-1:0] corner_x1,
  input  logic signed [snlm_pkg::COORD_W-1:0] corner_y1,
  input  logic signed [snlm_pkg::COORD_W-1:0] corner_x2,
  input  logic signed [snlm_pkg::COORD_W-1:0] corner_y2,
  input  logic [snlm_pkg::LEVEL_W-1:0]        red_level,
  input  logic [snlm_pkg::LEVEL_W-1:0]        green_level,
  input  logic [snlm_pkg::LEVEL_W-1:0]        blue_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [snlm_pkg::POS_W-1:0]          chain_position,
  output logic [snlm_pkg::LEVEL_W-1:0]        green_out,
  output logic [snlm_pkg::LEVEL_W-1:0]        red_out,
  output logic [snlm_pkg::LEVEL_W-1:0]        blue_out,
  output logic                                last_led
);
  import snlm_pkg::*;

  localparam int XY_W  = $clog2(SIDE);
  localparam int CNT_W = $clog2(LED_COUNT);
  localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'(SIDE - 1);

  logic [LEVEL_W-1:0] max_intensity;
  logic               accept;
  cmd_t               cmd_in;
  logic [XY_W-1:0]    cx1;
  logic [XY_W-1:0]    cy1;
  logic [XY_W-1:0]    cx2;
  logic [XY_W-1:0]    cy2;
  color_t             color;
  color_t             tail;
  color_t             cell_q [LED_COUNT];
  logic               busy;
  logic               out_free;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W+POS_W-1:0] pos_ext;
  ctl_t               ctl;

  function automatic logic [XY_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
    if (c < 0) begin
      clamp_coord = '0;
    end else if (c > COORD_MAX) begin
      clamp_coord = COORD_MAX[XY_W-1:0];
    end else begin
      clamp_coord = c[XY_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_intensity <= MAX_INTENSITY_RESET;
    end else if (cfg_write) begin
      max_intensity <= cfg_data;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign cmd_in   = cmd_t'(cmd);
  assign cx1      = clamp_coord(corner_x1);
  assign cy1      = clamp_coord(corner_y1);
  assign cx2      = clamp_coord(corner_x2);
  assign cy2      = clamp_coord(corner_y2);

  // Latch the write color; clear writes zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd_in == CMD_CLEAR) begin
        color <= '0;
      end else begin
        color.g <= clamp_level(green_level, max_intensity);
        color.r <= clamp_level(red_level, max_intensity);
        color.b <= clamp_level(blue_level, max_intensity);
      end
    end
  end

  snlm_ctrl #(
    .SIDE      (SIDE),
    .LED_COUNT (LED_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .cmd      (cmd_in),
    .x1       (cx1),
    .y1       (cy1),
    .x2       (cx2),
    .y2       (cy2),
    .out_free (out_free),
    .busy     (busy),
    .pos      (pos),
    .ctl      (ctl)
  );

  // The head cell re-enters at the tail, rewritten when the sequencer says so.
  assign tail = ctl.write ? color : cell_q[0];

  for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
    color_t d;
    if (i == LED_COUNT - 1) begin : g_tail
      assign d = tail;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    snlm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  assign out_free = !out_valid || !out_stall;
  assign pos_ext  = {{POS_W{1'b0}}, pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      chain_position <= pos_ext[POS_W-1:0];
      green_out      <= cell_q[0].g;
      red_out        <= cell_q[0].r;
      blue_out       <= cell_q[0].b;
      last_led       <= ctl.last;
    end
  end

endmodule
